// ===== rtl/psra_pkg.sv =====
// Shared types, codes and constants for the per-source packet rate alarm.
`timescale 1ns / 1ps

package psra_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam logic [15:0] IPV4_TYPE       = 16'h0800;
  localparam logic [15:0] THRESHOLD_RESET = 16'd500;
  localparam logic [31:0] WINDOW_RESET    = 32'd5;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'b1;

  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_NEW     = 3'd1;
  localparam logic [2:0] OUT_RESTART = 3'd2;
  localparam logic [2:0] OUT_COUNTED = 3'd3;
  localparam logic [2:0] OUT_ALERT   = 3'd4;
  localparam logic [2:0] OUT_FULL    = 3'd5;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [31:0] source_address;
    logic [31:0] arrival_time;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        alert;
    logic [15:0] packet_count;
    logic [31:0] alert_source;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic rd;
    logic step;
    logic emit_ignored;
    logic emit_new;
    logic emit_full;
    logic emit_update;
  } dp_cmd_t;

  typedef struct packed {
    logic ipv4;
    logic at_end;
    logic full;
    logic match;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/psra_ctrl.sv =====
// Sequencer for the source table scan, lookup result and update.
`timescale 1ns / 1ps

module psra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psra_pkg::dp_status_t status_i,
  output psra_pkg::dp_cmd_t    cmd_o
);

  psra_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psra_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = psra_pkg::ST_LOOK;
      end
      psra_pkg::ST_LOOK: begin
        if (!status_i.ipv4 || status_i.at_end) begin
          if (status_i.out_free) state_d = psra_pkg::ST_IDLE;
        end else begin
          state_d = psra_pkg::ST_CHECK;
        end
      end
      psra_pkg::ST_CHECK: begin
        state_d = status_i.match ? psra_pkg::ST_UPDATE : psra_pkg::ST_LOOK;
      end
      psra_pkg::ST_UPDATE: begin
        if (status_i.out_free) state_d = psra_pkg::ST_IDLE;
      end
      default: state_d = psra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      psra_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      psra_pkg::ST_LOOK: begin
        if (!status_i.ipv4) begin
          cmd_o.emit_ignored = status_i.out_free;
        end else if (status_i.at_end) begin
          cmd_o.emit_full = status_i.out_free && status_i.full;
          cmd_o.emit_new  = status_i.out_free && !status_i.full;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      psra_pkg::ST_CHECK: begin
        cmd_o.step = !status_i.match;
      end
      psra_pkg::ST_UPDATE: begin
        cmd_o.emit_update = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/psra_dp.sv =====
// Datapath: config registers, packet key, source table memory and result register.
`timescale 1ns / 1ps

module psra_dp #(
  parameter int unsigned TABLE_ENTRIES = psra_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psra_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psra_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  psra_pkg::in_word_t                 in_word_i,
  input  psra_pkg::dp_cmd_t                  cmd_i,
  output psra_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output psra_pkg::out_word_t                out_word_o
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef struct packed {
    logic [31:0] source;
    logic [15:0] count;
    logic [31:0] start;
  } entry_t;

  logic [15:0]         thr_q;
  logic [31:0]         win_q;
  psra_pkg::in_word_t  key_q;
  logic [CW-1:0]       idx_q;
  logic [CW-1:0]       fill_q;
  entry_t              rd_q;
  entry_t              mem_q [TABLE_ENTRIES];
  logic                wr_en;
  entry_t              wr_data;
  psra_pkg::out_word_t res;
  psra_pkg::out_word_t out_q;
  logic                out_valid_q;
  logic                emit;
  logic [31:0]         elapsed;
  logic                restart;
  logic [15:0]         cnt_inc;
  logic                hit_alert;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= psra_pkg::THRESHOLD_RESET;
      win_q <= psra_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        psra_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[15:0];
        psra_pkg::REG_WINDOW:    win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) key_q <= in_word_i;
  end

  // scan index and fill count; entries are never evicted, so valid ones are 0..fill-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.capture) idx_q <= '0;
      else if (cmd_i.step) idx_q <= idx_q + 1'b1;
      if (cmd_i.emit_new) fill_q <= fill_q + 1'b1;
    end
  end

  assign elapsed   = key_q.arrival_time - rd_q.start;
  assign restart   = elapsed > win_q;
  assign cnt_inc   = (rd_q.count == psra_pkg::COUNT_MAX) ? rd_q.count : rd_q.count + 16'd1;
  assign hit_alert = cnt_inc >= thr_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '{source: key_q.source_address, count: 16'd1, start: key_q.arrival_time};
    res     = '{outcome: psra_pkg::OUT_IGNORED, alert: 1'b0, packet_count: 16'd0,
                alert_source: 32'd0};
    if (cmd_i.emit_new) begin
      wr_en            = 1'b1;
      res.outcome      = psra_pkg::OUT_NEW;
      res.packet_count = 16'd1;
    end else if (cmd_i.emit_full) begin
      res.outcome = psra_pkg::OUT_FULL;
    end else if (cmd_i.emit_update) begin
      wr_en = 1'b1;
      if (restart) begin
        res.outcome      = psra_pkg::OUT_RESTART;
        res.packet_count = 16'd1;
      end else if (hit_alert) begin
        wr_data.count    = 16'd0;
        res.outcome      = psra_pkg::OUT_ALERT;
        res.alert        = 1'b1;
        res.packet_count = cnt_inc;
        res.alert_source = key_q.source_address;
      end else begin
        wr_data.count    = cnt_inc;
        wr_data.start    = rd_q.start;
        res.outcome      = psra_pkg::OUT_COUNTED;
        res.packet_count = cnt_inc;
      end
    end
  end

  // source table: one write or one read per cycle, both at the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[idx_q[AW-1:0]] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[idx_q[AW-1:0]];
  end

  assign emit = cmd_i.emit_ignored | cmd_i.emit_new | cmd_i.emit_full | cmd_i.emit_update;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign status_o.ipv4     = key_q.ether_type == psra_pkg::IPV4_TYPE;
  assign status_o.at_end   = idx_q == fill_q;
  assign status_o.full     = fill_q == CW'(TABLE_ENTRIES);
  assign status_o.match    = rd_q.source == key_q.source_address;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_new |-> (fill_q < CW'(TABLE_ENTRIES)))
    else $error("allocation into a full table");

  a_alloc_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_new |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("fill count did not advance on allocation");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a word not yet taken");

  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.emit_ignored, cmd_i.emit_new, cmd_i.emit_full, cmd_i.emit_update}))
    else $error("more than one result command at once");

endmodule

// ===== rtl/per_source_packet_rate_alarm.sv =====
// Top level of the per-source packet rate alarm: controller plus datapath.
`timescale 1ns / 1ps
//
//  channel   handshake                 payload                 direction
//  ------    ------------------------  ----------------------  ---------
//  in        in_valid_i / in_ready_o   in_word_i  (in_word_t)  in
//  out       out_valid_o / out_ready_i out_word_o (out_word_t) out
//  cfg       cfg_we_i                  cfg_index_i, cfg_data_i in
//
//  A word that is not IPv4 is dropped without a table scan. A new or untracked
//  source scans every stored source, and a known source scans the entries up
//  to its own table position. Each scan step is one memory read and one
//  address compare for a stored source.
//  Reset clears the fill count and the handshake state at once; no clearing pass.
//  A stalled output holds its word while the next input word is taken and
//  scanned; only the final result step waits for the output register to free.
//

module per_source_packet_rate_alarm #(
  parameter int unsigned TABLE_ENTRIES = psra_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psra_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psra_pkg::out_word_t             out_word_o
);

  // command and status between the sequencer and the table datapath
  psra_pkg::dp_cmd_t    cmd;
  psra_pkg::dp_status_t status;

  // sequencer: accept, scan the table entry by entry, then emit one result
  psra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: holds registers, key, source table and the output register
  psra_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/per_source_packet_rate_alarm_tb.sv =====
// Self-checking testbench for the per-source packet rate alarm: directed and random traffic.
`timescale 1ns / 1ps

module per_source_packet_rate_alarm_tb;

  localparam int TBL_N          = psra_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL_N         = 40;
  // Worst scan: a known source stored at the last position, plus slack.
  localparam int END_SETTLE     = 4 + 2 * TBL_N + 10;
  // Idle cycles allowed before the run is declared hung. The slowest correct
  // gap between two moved words is a full scan, a long output stall and a
  // long sender gap, well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;

  // Clock, reset and every block input start at a known value.
  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      cfg_we     = 1'b0;
  logic [psra_pkg::CFG_IDX_W-1:0]  cfg_index = psra_pkg::REG_THRESHOLD;
  logic [psra_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic      in_valid   = 1'b0;
  psra_pkg::in_word_t  in_word = '0;
  logic      out_ready  = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  psra_pkg::out_word_t out_word_o;

  per_source_packet_rate_alarm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Rate table mirror: per-source count and window start, plus the two
  // limits as last written. Updated once per accepted word.
  // ---------------------------------------------------------------------
  bit          src_live  [TBL_N];
  logic [31:0] src_addr  [TBL_N];
  logic [15:0] src_count [TBL_N];
  logic [31:0] src_start [TBL_N];
  logic [15:0] thr_model = psra_pkg::THRESHOLD_RESET;
  logic [31:0] win_model = psra_pkg::WINDOW_RESET;

  psra_pkg::out_word_t verdict_q [$];  // predicted result words, oldest first
  logic [31:0] src_pool [POOL_N];  // recurring sources for random traffic
  logic [31:0] wall_clock;         // arrival time base for random traffic

  int  fail_count     = 0;
  int  words_sent     = 0;
  int  limit_settings = 0;
  int  outcome_tally [6];
  int  idle_cycles    = 0;
  int  burst_left     = 0;
  bit  word_held      = 1'b0;      // valid left high for the next word
  int  ready_run      = 0;
  int  ready_hold     = 0;

  function automatic psra_pkg::out_word_t rate_table_step(input psra_pkg::in_word_t w);
    psra_pkg::out_word_t r;
    int          hit;
    int          free_slot;
    logic [31:0] elapsed;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    if (w.ether_type != psra_pkg::IPV4_TYPE) begin
      r.outcome = psra_pkg::OUT_IGNORED;
      return r;
    end
    // Lowest matching live entry wins; a new source takes the lowest free one.
    for (int i = 0; i < TBL_N; i++) begin
      if (src_live[i]) begin
        if (hit < 0 && src_addr[i] == w.source_address) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        r.outcome = psra_pkg::OUT_FULL;
        return r;
      end
      src_live[free_slot]  = 1'b1;
      src_addr[free_slot]  = w.source_address;
      src_count[free_slot] = 16'd1;
      src_start[free_slot] = w.arrival_time;
      r.outcome      = psra_pkg::OUT_NEW;
      r.packet_count = 16'd1;
      return r;
    end
    // Window age wraps modulo 2^32; restart only when strictly older.
    elapsed = w.arrival_time - src_start[hit];
    if (elapsed > win_model) begin
      src_count[hit] = 16'd1;
      src_start[hit] = w.arrival_time;
      r.outcome      = psra_pkg::OUT_RESTART;
      r.packet_count = 16'd1;
      return r;
    end
    if (src_count[hit] != psra_pkg::COUNT_MAX) src_count[hit] = src_count[hit] + 16'd1;
    if (src_count[hit] >= thr_model) begin
      r.outcome      = psra_pkg::OUT_ALERT;
      r.alert        = 1'b1;
      r.packet_count = src_count[hit];
      r.alert_source = w.source_address;
      src_count[hit] = 16'd0;
      src_start[hit] = w.arrival_time;
      return r;
    end
    r.outcome      = psra_pkg::OUT_COUNTED;
    r.packet_count = src_count[hit];
    return r;
  endfunction

  function automatic int entries_used();
    int n;
    n = 0;
    for (int i = 0; i < TBL_N; i++) if (src_live[i]) n++;
    return n;
  endfunction

  function automatic psra_pkg::in_word_t pkt_word(input logic [15:0] et,
                                                  input logic [31:0] src,
                                                  input logic [31:0] t_arr);
    psra_pkg::in_word_t w;
    w.ether_type     = et;
    w.source_address = src;
    w.arrival_time   = t_arr;
    return w;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. Within a
  // burst valid stays high and only the payload moves on.
  // ---------------------------------------------------------------------
  task automatic send_word(input psra_pkg::in_word_t w);
    if (!word_held) begin
      // Valid dropped at the last acceptance edge; wait a random idle gap first.
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(8, 20)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted at this edge: predict now so the order matches the block.
    verdict_q.push_back(rate_table_step(w));
    words_sent++;
    burst_left--;
    word_held = (burst_left > 0);
    if (!word_held) in_valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then wait with the block quiet.
  task automatic settle_block();
    if (word_held) begin
      in_valid <= 1'b0;
      word_held = 1'b0;
    end
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [psra_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psra_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    if (idx == psra_pkg::REG_THRESHOLD) thr_model = data[15:0];
    else if (idx == psra_pkg::REG_WINDOW) win_model = data;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Limits change only with the block idle. Junk in the upper threshold bits
  // must be dropped by the block.
  task automatic set_limits(input logic [15:0] thr, input logic [31:0] win);
    logic [15:0] junk;
    junk = 16'($urandom);
    settle_block();
    write_reg(psra_pkg::REG_THRESHOLD, {junk, thr});
    write_reg(psra_pkg::REG_WINDOW, win);
    limit_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: runs of ready, short stalls, and now and then a long one.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : out_stall_pattern
    if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      ready_run  = $urandom_range(0, 30);
      ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) :
                                                 $urandom_range(0, 3);
      out_ready <= 1'b1;
    end
  end

  // Compare each delivered result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    psra_pkg::out_word_t want;
    psra_pkg::out_word_t got;
    if (rst_ni && out_valid_o && out_ready) begin
      got = out_word_o;
      if (verdict_q.size() == 0) begin
        note_failure($sformatf("unexpected result: outcome %0d count %0d source %h",
                               got.outcome, got.packet_count, got.alert_source));
      end else begin
        want = verdict_q.pop_front();
        outcome_tally[want.outcome]++;
        if (got.outcome !== want.outcome || got.alert !== want.alert ||
            got.packet_count !== want.packet_count ||
            got.alert_source !== want.alert_source) begin
          note_failure($sformatf({"mismatch (expected/actual): outcome %0d/%0d ",
                                  "alert %0b/%0b count %0d/%0d source %h/%h"},
                                 want.outcome, got.outcome, want.alert, got.alert,
                                 want.packet_count, got.packet_count,
                                 want.alert_source, got.alert_source));
        end
      end
    end
  end

  // Hang detector: count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles, %0d results pending",
               $realtime, idle_cycles, verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset limits (threshold 500, window 5): non-IPv4 drops, field extremes,
  // window edge exactly at and past the limit, and a wrapped age.
  task automatic test_reset_defaults();
    send_word(pkt_word(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(pkt_word(16'hFFFF, 32'h0000_0000, 32'h0000_0000));
    send_word(pkt_word(16'h0801, 32'h0000_0001, 32'h0000_0001));
    send_word(pkt_word(16'h86DD, 32'h8000_0000, 32'h8000_0000));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0000_0000, 32'd0));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0000_0000, 32'd5));   // age equals window
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0000_0000, 32'd11));  // age past window
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hFFFF_FFFF, 32'd3));   // age wraps to 5
  endtask

  // Threshold of one: no alert on the first packet, then every count alerts.
  // Threshold of zero: any counted packet alerts.
  task automatic test_threshold_edges();
    set_limits(16'd1, 32'hFFFF_FFFF);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hA5A5_5A5A, 32'd0));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hA5A5_5A5A, 32'd100));
    // backwards, still in window
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hA5A5_5A5A, 32'd7));
    set_limits(16'd0, 32'hFFFF_FFFF);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hA5A5_5A5A, 32'd8));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hA5A5_5A5A, 32'd9));
  endtask

  // Lower the threshold below a stored count: the next counted packet alerts.
  task automatic test_threshold_lowered();
    set_limits(16'd100, 32'd1000);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0A00_0001, 32'd50));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0A00_0001, 32'd51));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0A00_0001, 32'd52));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0A00_0001, 32'd53));
    set_limits(16'd3, 32'd1000);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'h0A00_0001, 32'd54));
  endtask

  // Zero window: same second counts, next second restarts. Full window never
  // restarts, even across the wrap.
  task automatic test_window_edges();
    set_limits(16'hFFFF, 32'd0);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hC0A8_0101, 32'h8000_0000));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hC0A8_0101, 32'h8000_0000));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hC0A8_0101, 32'h8000_0001));
    set_limits(16'hFFFF, 32'hFFFF_FFFF);
    send_word(pkt_word(psra_pkg::IPV4_TYPE, 32'hC0A8_0101, 32'h0000_0000));
  endtask

  // Mostly IPv4 from a few hot sources on a slowly ticking clock, so counts
  // build up to alerts; some noise types, stray times and clock jumps. Once
  // the table is full, unseen sources show up as untracked.
  task automatic test_random_traffic(input int n_ipv4, input logic [15:0] thr,
                                     input logic [31:0] win, input int tick_odds,
                                     input bit table_full);
    int          sent;
    int          r;
    logic [31:0] src;
    logic [31:0] t_pkt;
    logic [15:0] et;
    set_limits(thr, win);
    sent = 0;
    while (sent < n_ipv4) begin
      r = $urandom_range(0, 99);
      if (r < 55) src = src_pool[$urandom_range(0, 3)];
      else if (r < 92 || !table_full) src = src_pool[$urandom_range(4, POOL_N - 1)];
      else src = $urandom;
      // Advance the arrival clock: mostly slow ticks, now and then a jump.
      r = $urandom_range(0, 99);
      if (r < 2) wall_clock = $urandom;
      else if (r < 5) wall_clock = wall_clock + $urandom_range(0, 8);
      else if ($urandom_range(1, tick_odds) == 1) wall_clock = wall_clock + 1;
      t_pkt = wall_clock;
      if ($urandom_range(0, 99) < 3) t_pkt = $urandom;
      et = psra_pkg::IPV4_TYPE;
      if ($urandom_range(0, 99) < 12) et = 16'($urandom);
      if (et == psra_pkg::IPV4_TYPE) sent++;
      send_word(pkt_word(et, src, t_pkt));
    end
  endtask

  // Fill the table with fresh sources, then knock with more new ones, a non-IPv4 word and a pool source.
  task automatic test_table_full();
    set_limits(16'd8, 32'd20);
    while (entries_used() < TBL_N)
      send_word(pkt_word(psra_pkg::IPV4_TYPE, $urandom, $urandom));
    repeat (4) send_word(pkt_word(psra_pkg::IPV4_TYPE, $urandom, $urandom));
    send_word(pkt_word(16'h0806, $urandom, $urandom));
    send_word(pkt_word(psra_pkg::IPV4_TYPE, src_pool[0], wall_clock));
  endtask

  initial begin
    for (int i = 0; i < POOL_N; i++) src_pool[i] = $urandom;
    wall_clock = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_threshold_edges();
    test_threshold_lowered();
    test_window_edges();

    // Random traffic with room left in the table.
    wall_clock = $urandom;
    test_random_traffic(62, 16'd4, 32'd5, 8, 1'b0);
    wall_clock = 32'hFFFF_FFF0;
    test_random_traffic(62, 16'd1, 32'd0, 4, 1'b0);
    wall_clock = $urandom;
    test_random_traffic(62, 16'hFFFF, 32'hFFFF_FFFF, 2, 1'b0);
    test_random_traffic(62, 16'($urandom_range(2, 12)), $urandom_range(0, 8), 6, 1'b0);
    test_random_traffic(62, 16'd3, 32'd2, 10, 1'b0);

    test_table_full();

    // Random traffic against a full table.
    wall_clock = $urandom;
    test_random_traffic(62, 16'd6, 32'd10, 8, 1'b1);
    wall_clock = 32'hFFFF_FFF8;
    test_random_traffic(62, 16'd2, 32'hFFFF_FFFF, 3, 1'b1);
    test_random_traffic(62, 16'($urandom_range(1, 65535)), $urandom, 5, 1'b1);
    test_random_traffic(62, psra_pkg::THRESHOLD_RESET, psra_pkg::WINDOW_RESET, 8, 1'b1);
    test_random_traffic(62, 16'($urandom_range(2, 8)), $urandom_range(1, 6), 6, 1'b1);

    // Drain, then hold long enough for a stray late result to show up.
    settle_block();
    repeat (END_SETTLE) @(posedge clk_i);
    if (verdict_q.size() != 0)
      note_failure($sformatf("%0d predicted results never arrived", verdict_q.size()));

    $display("Run: %0d packets over %0d limit settings, table at %0d of %0d entries.",
             words_sent, limit_settings, entries_used(), TBL_N);
    $display({"Outcomes: %0d ignored, %0d new, %0d restarted, %0d counted, ",
              "%0d alerts, %0d untracked; %0d failures."},
             outcome_tally[psra_pkg::OUT_IGNORED], outcome_tally[psra_pkg::OUT_NEW],
             outcome_tally[psra_pkg::OUT_RESTART], outcome_tally[psra_pkg::OUT_COUNTED],
             outcome_tally[psra_pkg::OUT_ALERT], outcome_tally[psra_pkg::OUT_FULL],
             fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== per_source_packet_rate_alarm.f =====
rtl/psra_pkg.sv
rtl/psra_ctrl.sv
rtl/psra_dp.sv
rtl/per_source_packet_rate_alarm.sv
tb/per_source_packet_rate_alarm_tb.sv
